// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/arp_pkg.sv
// Package for the ARP cache: constants, request and result codes, state enum.
`default_nettype none
package arp_pkg;
    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int PENDING_SLOTS_DEF = 8;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TIME_W = 16;
    localparam int TRY_W  = 3;
    localparam int TMO_W  = 8;
    localparam int CFG_W  = 8;
    localparam logic [7:0] TIMEOUT_RST  = 8'd15;
    localparam logic [2:0] MAXTRIES_RST = 3'd5;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUEUE  = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [2:0] RES_LOOKUP  = 3'd0;
    localparam logic [2:0] RES_INSERT  = 3'd1;
    localparam logic [2:0] RES_QUEUE   = 3'd2;
    localparam logic [2:0] RES_SEND    = 3'd3;
    localparam logic [2:0] RES_RESOLVE = 3'd4;
    localparam logic [2:0] RES_UNREACH = 3'd5;
    localparam logic [2:0] RES_DONE    = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_MAXTRIES = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSCAN,    // cache scan: read entry, compare
        S_CSCAN_W,  // read latency
        S_PSCAN,
        S_PSCAN_W,
        S_AGE,
        S_AGE_W,
        S_TSLOT,    // tick: read pending slot
        S_TSLOT_W,
        S_TFIND,    // tick: scan cache for slot ip
        S_TFIND_W,
        S_TEMIT,
        S_FINISH
    } state_t;
endpackage
`default_nettype wire

// File: rtl/arp_cache_with_retry_top.sv
// Top level of the ARP cache with aging and pending resolution retry.
// A lookup scans the cache, an insert scans the cache and then the pending slots, and a
// queue scans the pending slots. A tick ages the cache, then reads each pending slot and
// scans the cache for each live one, giving a result per live slot before the last.
// One request at a time; busy drops in the cycle of the last result. Results cannot be
// held off. Reset clears valid bits, clock and state registers; config goes to defaults.
`default_nettype none
module arp_cache_with_retry_top #(
    parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_SLOTS = arp_pkg::PENDING_SLOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               req_type,
    input  wire logic [arp_pkg::IP_W-1:0] ip_addr,
    input  wire logic [arp_pkg::MAC_W-1:0] mac_addr,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [arp_pkg::CFG_W-1:0] cfg_data,
    output logic                          result_valid,
    output logic [2:0]                    result_kind,
    output logic [arp_pkg::IP_W-1:0]      out_ip,
    output logic [arp_pkg::MAC_W-1:0]     out_mac,
    output logic                          found,
    output logic [1:0]                    status,
    output logic                          last
);
    import arp_pkg::*;

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    // Memories: cache entries and pending slots, synchronous read.
    logic [IP_W-1:0]   c_ip_mem  [CACHE_ENTRIES];
    logic [MAC_W-1:0]  c_mac_mem [CACHE_ENTRIES];
    logic [TIME_W-1:0] c_add_mem [CACHE_ENTRIES];
    logic [IP_W-1:0]   p_ip_mem  [PENDING_SLOTS];
    logic [TRY_W-1:0]  p_try_mem [PENDING_SLOTS];

    logic [CACHE_ENTRIES-1:0] c_valid_reg, c_valid_next;
    logic [PENDING_SLOTS-1:0] p_valid_reg, p_valid_next;

    logic [IP_W-1:0]   c_ip_q;
    logic [MAC_W-1:0]  c_mac_q;
    logic [TIME_W-1:0] c_add_q;
    logic [IP_W-1:0]   p_ip_q;
    logic [TRY_W-1:0]  p_try_q;

    logic [CW-1:0] c_addr;
    logic          c_we;
    logic [PW-1:0] p_addr;
    logic          p_we;
    logic [TRY_W-1:0] p_try_wr;

    state_t state_reg, state_next;
    logic [CW:0] ci_reg, ci_next;   // cache index, one bit wider than the entry address
    logic [PW:0] pi_reg, pi_next;
    logic [1:0]  rt_reg, rt_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [TIME_W-1:0] sec_reg, sec_next;
    logic [TMO_W-1:0] tmo_reg;
    logic [TRY_W-1:0] mtry_reg;
    // scan outcomes
    logic          hit_reg, hit_next;
    logic [MAC_W-1:0] hmac_reg, hmac_next;
    logic          ffree_reg, ffree_next;     // a free cache slot was seen
    logic [CW-1:0] free_reg, free_next;
    logic          pfound_reg, pfound_next;
    logic [PW-1:0] pidx_reg, pidx_next;
    logic          pfree_reg, pfree_next;
    logic [PW-1:0] pfidx_reg, pfidx_next;

    logic rv_next, fnd_next, lst_next;
    logic [2:0] kind_next;
    logic [IP_W-1:0] oip_next;
    logic [MAC_W-1:0] omac_next;
    logic [1:0] st_next;

    logic [CW-1:0] ci_lo;
    logic [PW-1:0] pi_lo;
    logic          c_end, p_end;
    logic [TIME_W-1:0] age;

    assign ci_lo = ci_reg[CW-1:0];
    assign pi_lo = pi_reg[PW-1:0];
    assign c_end = (ci_reg == (CW+1)'(CACHE_ENTRIES - 1));
    assign p_end = (pi_reg == (PW+1)'(PENDING_SLOTS - 1));
    assign age   = sec_reg - c_add_q;

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_ip_mem[c_addr]  <= ip_reg;
            c_mac_mem[c_addr] <= mac_reg;
            c_add_mem[c_addr] <= sec_reg;
        end
        c_ip_q  <= c_ip_mem[c_addr];
        c_mac_q <= c_mac_mem[c_addr];
        c_add_q <= c_add_mem[c_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_ip_mem[p_addr]  <= ip_reg;
            p_try_mem[p_addr] <= p_try_wr;
        end
        p_ip_q  <= p_ip_mem[p_addr];
        p_try_q <= p_try_mem[p_addr];
    end

    // Config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg  <= TIMEOUT_RST;
            mtry_reg <= MAXTRIES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:  tmo_reg  <= cfg_data;
                CFG_MAXTRIES: mtry_reg <= cfg_data[TRY_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            c_valid_reg  <= '0;
            p_valid_reg  <= '0;
            sec_reg      <= '0;
            ci_reg       <= '0;
            pi_reg       <= '0;
            rt_reg       <= '0;
            hit_reg      <= 1'b0;
            ffree_reg    <= 1'b0;
            pfound_reg   <= 1'b0;
            pfree_reg    <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            c_valid_reg  <= c_valid_next;
            p_valid_reg  <= p_valid_next;
            sec_reg      <= sec_next;
            ci_reg       <= ci_next;
            pi_reg       <= pi_next;
            rt_reg       <= rt_next;
            hit_reg      <= hit_next;
            ffree_reg    <= ffree_next;
            pfound_reg   <= pfound_next;
            pfree_reg    <= pfree_next;
            result_valid <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg      <= ip_next;
        mac_reg     <= mac_next;
        hmac_reg    <= hmac_next;
        free_reg    <= free_next;
        pidx_reg    <= pidx_next;
        pfidx_reg   <= pfidx_next;
        result_kind <= kind_next;
        out_ip      <= oip_next;
        out_mac     <= omac_next;
        found       <= fnd_next;
        status      <= st_next;
        last        <= lst_next;
    end

    assign busy = (state_reg != S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (req_type == REQ_TICK) ? S_AGE :
                                 (req_type == REQ_QUEUE) ? S_PSCAN : S_CSCAN;
            S_CSCAN:   state_next = S_CSCAN_W;
            S_CSCAN_W:
                if (!c_end)
                    state_next = S_CSCAN;
                else
                    state_next = (rt_reg == REQ_INSERT) ? S_PSCAN : S_FINISH;
            S_PSCAN:   state_next = S_PSCAN_W;
            S_PSCAN_W: state_next = p_end ? S_FINISH : S_PSCAN;
            S_AGE:     state_next = S_AGE_W;
            S_AGE_W:   state_next = c_end ? S_TSLOT : S_AGE;
            S_TSLOT:   state_next = S_TSLOT_W;
            S_TSLOT_W: state_next = p_valid_reg[pi_lo] ? S_TFIND :
                                    (p_end ? S_FINISH : S_TSLOT);
            S_TFIND:   state_next = S_TFIND_W;
            S_TFIND_W: state_next = c_end ? S_TEMIT : S_TFIND;
            S_TEMIT:   state_next = p_end ? S_FINISH : S_TSLOT;
            S_FINISH:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        c_valid_next = c_valid_reg;
        p_valid_next = p_valid_reg;
        sec_next   = sec_reg;
        ci_next    = ci_reg;
        pi_next    = pi_reg;
        rt_next    = rt_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        hit_next   = hit_reg;
        hmac_next  = hmac_reg;
        ffree_next = ffree_reg;
        free_next  = free_reg;
        pfound_next = pfound_reg;
        pidx_next  = pidx_reg;
        pfree_next = pfree_reg;
        pfidx_next = pfidx_reg;
        c_addr = ci_lo;
        c_we   = 1'b0;
        p_addr = pi_lo;
        p_we   = 1'b0;
        p_try_wr = '0;
        rv_next   = 1'b0;
        kind_next = RES_LOOKUP;
        oip_next  = '0;
        omac_next = '0;
        fnd_next  = 1'b0;
        st_next   = ST_OK;
        lst_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ci_next = '0;
                pi_next = '0;
                rt_next = req_type;
                ip_next = ip_addr;
                mac_next = mac_addr;
                hit_next = 1'b0;
                ffree_next = 1'b0;
                pfound_next = 1'b0;
                pfree_next = 1'b0;
                if (start && req_type == REQ_TICK)
                    sec_next = sec_reg + 1'b1;
            end
            S_CSCAN_W, S_TFIND_W:
            begin
                if (c_valid_reg[ci_lo] && c_ip_q == ip_reg)
                begin
                    hit_next  = 1'b1;
                    hmac_next = c_mac_q;
                end
                if (!c_valid_reg[ci_lo] && !ffree_reg)
                begin
                    ffree_next = 1'b1;
                    free_next  = ci_lo;
                end
                ci_next = c_end ? '0 : ci_reg + 1'b1;
            end
            S_PSCAN_W:
            begin
                if (p_valid_reg[pi_lo] && p_ip_q == ip_reg && !pfound_reg)
                begin
                    pfound_next = 1'b1;
                    pidx_next   = pi_lo;
                end
                if (!p_valid_reg[pi_lo] && !pfree_reg)
                begin
                    pfree_next = 1'b1;
                    pfidx_next = pi_lo;
                end
                pi_next = p_end ? '0 : pi_reg + 1'b1;
            end
            S_AGE_W:
            begin
                if (c_valid_reg[ci_lo] && age > TIME_W'(tmo_reg))
                    c_valid_next[ci_lo] = 1'b0;
                ci_next = c_end ? '0 : ci_reg + 1'b1;
            end
            S_TSLOT_W:
            begin
                ip_next  = p_ip_q;
                hit_next = 1'b0;
                if (!p_valid_reg[pi_lo])
                    pi_next = pi_reg + 1'b1;
            end
            S_TEMIT:
            begin
                rv_next  = 1'b1;
                oip_next = ip_reg;
                if (hit_reg)
                begin
                    kind_next = RES_RESOLVE;
                    omac_next = hmac_reg;
                    fnd_next  = 1'b1;
                    p_valid_next[pi_lo] = 1'b0;
                end
                else if (p_try_q >= mtry_reg)
                begin
                    kind_next = RES_UNREACH;
                    p_valid_next[pi_lo] = 1'b0;
                end
                else
                begin
                    kind_next = RES_SEND;
                    p_we = 1'b1;
                    p_try_wr = p_try_q + 1'b1;
                end
                pi_next = pi_reg + 1'b1;
            end
            S_FINISH:
            begin
                rv_next  = 1'b1;
                lst_next = 1'b1;
                oip_next = ip_reg;
                case (rt_reg)
                    REQ_LOOKUP:
                    begin
                        kind_next = RES_LOOKUP;
                        fnd_next  = hit_reg;
                        omac_next = hit_reg ? hmac_reg : '0;
                    end
                    REQ_INSERT:
                    begin
                        kind_next = RES_INSERT;
                        fnd_next  = pfound_reg;
                        if (pfound_reg)
                            p_valid_next[pidx_reg] = 1'b0;
                        if (ffree_reg)
                        begin
                            c_addr = free_reg;
                            c_we   = 1'b1;
                            c_valid_next[free_reg] = 1'b1;
                        end
                        else
                            st_next = ST_FULL;
                    end
                    REQ_QUEUE:
                    begin
                        kind_next = RES_QUEUE;
                        if (pfound_reg)
                            st_next = ST_PENDING;
                        else if (pfree_reg)
                        begin
                            p_addr = pfidx_reg;
                            p_we   = 1'b1;
                            p_try_wr = '0;
                            p_valid_next[pfidx_reg] = 1'b1;
                        end
                        else
                            st_next = ST_FULL;
                    end
                    default:
                    begin
                        kind_next = RES_DONE;
                        oip_next  = '0;
                    end
                endcase
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/arp_chk.sv
// Port-level checker for the ARP cache, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module arp_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       result_valid,
    input wire logic [2:0] result_kind,
    input wire logic       last
);
    import arp_pkg::*;
    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted request not busy")
    `CHK_IMPL(a_last_kind, clk, rst_n, result_valid && last, result_kind != RES_SEND && result_kind != RES_RESOLVE && result_kind != RES_UNREACH, "retry result marked last")
    `CHK_IMPL(a_done_last, clk, rst_n, result_valid && result_kind == RES_DONE, last, "tick done not last")
    `CHK_NEXT(a_last_idle, clk, rst_n, result_valid && last, !result_valid, "result after last")
endmodule
bind arp_cache_with_retry_top arp_chk u_arp_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result_kind(result_kind), .last(last)
);
`default_nettype wire
